FILE: rtl/core/swd_pkg.sv
package swd_pkg;

    localparam int VEL_W    = 16;
    localparam int LEN_W    = 16;
    localparam int SPEED_W  = 17;
    localparam int ANGLE_W  = 15;
    localparam int XY_W     = 34;
    localparam int PROD_W   = 33;
    localparam int Q_W      = 27;
    localparam int Z_W      = 25;
    localparam int ATAN_W   = 22;
    localparam int NORM_MSB = 29;

    localparam int CORDIC_STEPS = 23;
    localparam int DIV_LAT      = Q_W + 3;
    localparam int SQRT_LAT     = Q_W + 3;
    localparam int ANG_LAT      = CORDIC_STEPS + 4;
    localparam int QUEUE_DEPTH  = 4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK     = 2'd1;

    localparam logic [LEN_W-1:0]   LEN_RESET   = 16'd1000;
    localparam logic [LEN_W-1:0]   TRACK_RESET = 16'd1000;
    localparam logic [Q_W-1:0]     Q_CLAMP     = 27'h400_0000;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 17'h1_FFFF;
    localparam logic [ANGLE_W-1:0] ANGLE_FULL  = 15'd23040;
    localparam logic [Z_W-1:0]     DEG90       = 25'd5898240;
    localparam logic [Z_W-1:0]     DEG180      = 25'd11796480;
    localparam logic [Z_W-1:0]     DEG360      = 25'd23592960;

    typedef struct packed {
        logic signed [XY_W-1:0] xl;
        logic signed [XY_W-1:0] xr;
        logic signed [XY_W-1:0] yf;
        logic signed [XY_W-1:0] yr;
    } t_cmd;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/swd_front.sv
module swd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [swd_pkg::VEL_W-1:0]   i_fwd,
    input  logic signed [swd_pkg::VEL_W-1:0]   i_rot,
    input  logic        [swd_pkg::LEN_W-1:0]   i_len,
    input  logic        [swd_pkg::LEN_W-1:0]   i_track,
    input  logic                               i_full,
    output logic                               o_push,
    output swd_pkg::t_cmd                      o_cmd
);

    logic                               r_valid;
    logic                               n_valid;
    logic                               advance;
    logic signed [swd_pkg::PROD_W-1:0]  r_p_fl;
    logic signed [swd_pkg::PROD_W-1:0]  r_p_rw;
    logic signed [swd_pkg::PROD_W-1:0]  r_p_rl;
    logic signed [swd_pkg::XY_W-1:0]    base;
    logic signed [swd_pkg::XY_W-1:0]    side;
    logic signed [swd_pkg::XY_W-1:0]    rl;

    assign advance = !r_valid || !i_full;
    assign o_ready = advance;
    assign o_push  = r_valid && !i_full;
    assign n_valid = advance ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_p_fl <= i_fwd * $signed({1'b0, i_len});
            r_p_rw <= i_rot * $signed({1'b0, i_track});
            r_p_rl <= i_rot * $signed({1'b0, i_len});
        end
    end

    assign base = {r_p_fl, 1'b0};
    assign side = {r_p_rw[swd_pkg::PROD_W-1], r_p_rw};
    assign rl   = {r_p_rl[swd_pkg::PROD_W-1], r_p_rl};

    assign o_cmd.xl = base - side;
    assign o_cmd.xr = base + side;
    assign o_cmd.yf = rl + {r_p_rl, 1'b0};
    assign o_cmd.yr = rl;

endmodule

FILE: rtl/core/swd_fifo.sv
module swd_fifo #(
    parameter int DEPTH = swd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  swd_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output swd_pkg::t_cmd o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    swd_pkg::t_cmd   r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/swd_div.sv
module swd_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [swd_pkg::XY_W-1:0]   i_x,
    input  logic        [swd_pkg::LEN_W-1:0]  i_len,
    output logic        [swd_pkg::Q_W-1:0]    o_q
);

    localparam int XW = swd_pkg::XY_W;
    localparam int QW = swd_pkg::Q_W;
    localparam int NW = XW + 9;
    localparam int DW = swd_pkg::LEN_W + 1;

    logic [XW-1:0] ux;
    logic [XW-1:0] mag;
    logic [NW-1:0] r_n;
    logic [DW-1:0] r_d;
    logic [DW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_dd  [QW+1];
    logic [QW-1:0] r_lo  [QW+1];
    logic [QW-1:0] r_qb  [QW+1];
    logic          r_ovf [QW+1];
    logic [QW-1:0] r_q;

    assign ux  = i_x;
    assign mag = ux[XW-1] ? (~ux + 1'b1) : ux;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= {1'b0, mag, 8'b0} + NW'(i_len);
            r_d <= {i_len, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= ({1'b0, r_n} >= {r_d, QW'(0)});
            r_rem[0] <= DW'(r_n[NW-1:QW]);
            r_lo[0]  <= r_n[QW-1:0];
            r_qb[0]  <= '0;
            r_dd[0]  <= r_d;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] t;
        logic        ge;

        assign t  = {r_rem[k], r_lo[k][QW-1]};
        assign ge = (t >= {1'b0, r_dd[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? DW'(t - {1'b0, r_dd[k]}) : t[DW-1:0];
                r_lo[k+1]  <= {r_lo[k][QW-2:0], 1'b0};
                r_qb[k+1]  <= {r_qb[k][QW-2:0], ge};
                r_dd[k+1]  <= r_dd[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= (r_ovf[QW] || (r_qb[QW] > swd_pkg::Q_CLAMP)) ? swd_pkg::Q_CLAMP : r_qb[QW];
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/core/swd_sqrt.sv
module swd_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [swd_pkg::Q_W-1:0]        i_qx,
    input  logic [swd_pkg::Q_W-1:0]        i_qy,
    output logic [swd_pkg::SPEED_W-1:0]    o_speed
);

    localparam int QW = swd_pkg::Q_W;
    localparam int VW = 2 * QW;
    localparam int RW = QW + 2;

    logic [VW-1:0] r_sx;
    logic [VW-1:0] r_sy;
    logic [VW-1:0] r_v    [QW+1];
    logic [RW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_root [QW+1];
    logic [QW:0]   rnd;
    logic [QW-8:0] scaled;
    logic [swd_pkg::SPEED_W-1:0] r_speed;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= i_qx * i_qx;
            r_sy <= i_qy * i_qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]    <= r_sx + r_sy;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        logic          ge;

        assign t     = {r_rem[k], r_v[k][VW-1:VW-2]};
        assign trial = {2'b00, r_root[k], 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? RW'(t - trial) : t[RW-1:0];
                r_root[k+1] <= {r_root[k][QW-2:0], ge};
                r_v[k+1]    <= {r_v[k][VW-3:0], 2'b00};
            end
        end
    end

    assign rnd    = {1'b0, r_root[QW]} + (QW+1)'(128);
    assign scaled = rnd[QW:8];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_speed <= (scaled > (QW-7)'(swd_pkg::SPEED_MAX)) ? swd_pkg::SPEED_MAX
                                                              : scaled[swd_pkg::SPEED_W-1:0];
        end
    end

    assign o_speed = r_speed;

endmodule

FILE: rtl/core/swd_angle.sv
module swd_angle (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [swd_pkg::XY_W-1:0]   i_x,
    input  logic signed [swd_pkg::XY_W-1:0]   i_y,
    output logic        [swd_pkg::ANGLE_W-1:0] o_angle
);

    localparam int XW = swd_pkg::XY_W;
    localparam int ZW = swd_pkg::Z_W;
    localparam int NS = swd_pkg::CORDIC_STEPS;
    localparam int NB = swd_pkg::NORM_MSB + 1;

    typedef struct packed {
        logic xn;
        logic yn;
        logic az;
        logic bz;
    } t_ang_flags;

    logic [XW-1:0]   ux;
    logic [XW-1:0]   uy;
    logic [XW-1:0]   r_a;
    logic [XW-1:0]   r_b;
    t_ang_flags      r_f1;
    logic [XW-1:0]   r_a2;
    logic [XW-1:0]   r_b2;
    t_ang_flags      r_f2;
    logic            r_shr;
    logic [5:0]      r_amt;
    logic [XW-1:0]   m;
    logic [5:0]      pos;
    logic [NB-1:0]   an;
    logic [NB-1:0]   bn;

    logic signed [XW-1:0] r_cx [NS+1];
    logic signed [XW-1:0] r_cy [NS+1];
    logic signed [ZW-1:0] r_cz [NS+1];
    t_ang_flags           r_cf [NS+1];

    logic [ZW-1:0]   t;
    logic [ZW-1:0]   total;
    logic [ZW-1:0]   rnd;
    logic [swd_pkg::ANGLE_W-1:0] r_angle;

    assign ux = i_x;
    assign uy = i_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= ux[XW-1] ? (~ux + 1'b1) : ux;
            r_b     <= uy[XW-1] ? (~uy + 1'b1) : uy;
            r_f1.xn <= ux[XW-1];
            r_f1.yn <= uy[XW-1];
            r_f1.az <= (ux == '0);
            r_f1.bz <= (uy == '0);
        end
    end

    assign m = (r_a > r_b) ? r_a : r_b;

    always_comb begin
        pos = '0;
        for (int i = 0; i < XW; i++) begin
            if (m[i]) begin
                pos = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2  <= r_a;
            r_b2  <= r_b;
            r_f2  <= r_f1;
            r_shr <= (pos >= 6'(swd_pkg::NORM_MSB));
            r_amt <= (pos >= 6'(swd_pkg::NORM_MSB)) ? pos - 6'(swd_pkg::NORM_MSB)
                                                   : 6'(swd_pkg::NORM_MSB) - pos;
        end
    end

    always_comb begin
        logic [XW+NB-1:0] la;
        logic [XW+NB-1:0] lb;
        logic [XW-1:0]    ra;
        logic [XW-1:0]    rb;
        la = {{NB{1'b0}}, r_a2} << r_amt;
        lb = {{NB{1'b0}}, r_b2} << r_amt;
        ra = r_a2 >> r_amt;
        rb = r_b2 >> r_amt;
        an = r_shr ? ra[NB-1:0] : la[NB-1:0];
        bn = r_shr ? rb[NB-1:0] : lb[NB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= $signed(XW'(an));
            r_cy[0] <= $signed(XW'(bn));
            r_cz[0] <= '0;
            r_cf[0] <= r_f2;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_cordic
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] at;
        logic                 pos_y;

        assign xs    = r_cx[k] >>> k;
        assign ys    = r_cy[k] >>> k;
        assign at    = $signed(ZW'(swd_pkg::atan_lut(5'(k))));
        assign pos_y = !r_cy[k][XW-1] && (r_cy[k] != '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cx[k+1] <= pos_y ? r_cx[k] + ys : r_cx[k] - ys;
                r_cy[k+1] <= pos_y ? r_cy[k] - xs : r_cy[k] + xs;
                r_cz[k+1] <= pos_y ? r_cz[k] + at : r_cz[k] - at;
                r_cf[k+1] <= r_cf[k];
            end
        end
    end

    always_comb begin
        if (r_cf[NS].az) begin
            t = swd_pkg::DEG90;
        end else if (r_cf[NS].bz || r_cz[NS][ZW-1]) begin
            t = '0;
        end else if (r_cz[NS] > $signed(swd_pkg::DEG90)) begin
            t = swd_pkg::DEG90;
        end else begin
            t = r_cz[NS];
        end

        if (r_cf[NS].az && r_cf[NS].bz) begin
            total = '0;
        end else if (!r_cf[NS].xn && !r_cf[NS].yn) begin
            total = t;
        end else if (r_cf[NS].xn && !r_cf[NS].yn) begin
            total = swd_pkg::DEG180 - t;
        end else if (r_cf[NS].xn) begin
            total = swd_pkg::DEG180 + t;
        end else begin
            total = swd_pkg::DEG360 - t;
        end

        rnd = total + ZW'(512);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= (rnd[ZW-1:10] >= swd_pkg::ANGLE_FULL) ?
                       rnd[ZW-1:10] - swd_pkg::ANGLE_FULL : rnd[ZW-1:10];
        end
    end

    assign o_angle = r_angle;

endmodule

FILE: rtl/core/swerve_wheel_speed_angle_unit.sv
// Swerve drive inverse kinematics: one drive command in, four wheel speeds and
// four steering angles out.
// The input stream takes a command beat of forward velocity and rotation, both
// signed Q8.8. The output stream gives one beat per command with, for each wheel,
// its speed in unsigned Q9.8 and its steering angle in 1/64 degree.
// The configuration channel writes the wheelbase length (index 0) and the track
// width (index 1); it is always ready. The user must write it only while no
// command is in flight; the block does not enforce this. A wheelbase length of
// zero acts as one. An accepted command passes the multiplier stage, the command
// queue, and then the restoring dividers and the square-root pipeline (30 register
// stages each, the first of which captures the queue head). The steering CORDIC
// runs alongside and is delayed to match. One command is accepted and one result
// given per cycle while the receiver does not stall.
// When the receiver stalls, the whole back pipeline holds and the result stays on
// the output; the queue then fills, and the input stalls once the queue and the
// multiplier stage are both full.
// Reset clears the pipeline valids, the queue and the registers to 1000 mm each.
module swerve_wheel_speed_angle_unit #(
    parameter int QUEUE_DEPTH = swd_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // forward_velocity, rotation_rate
    input  logic [31:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // front_left_speed, front_left_angle, front_right_speed, front_right_angle,
    // rear_left_speed, rear_left_angle, rear_right_speed, rear_right_angle
    output logic [127:0]                      m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swd_pkg::LEN_W-1:0]         i_cfg_data
);

    localparam int LAT     = swd_pkg::DIV_LAT + swd_pkg::SQRT_LAT;
    localparam int ANG_DLY = LAT - swd_pkg::ANG_LAT;
    localparam int AW      = swd_pkg::ANGLE_W;
    localparam int SW      = swd_pkg::SPEED_W;

    logic [swd_pkg::LEN_W-1:0] r_len;
    logic [swd_pkg::LEN_W-1:0] r_track;
    logic [swd_pkg::LEN_W-1:0] len_eff;

    logic          w_full;
    logic          w_push;
    swd_pkg::t_cmd w_cmd;
    logic          w_head_valid;
    swd_pkg::t_cmd w_head;
    logic          en;
    logic          pop;
    logic [LAT-1:0] r_vld;

    logic signed [swd_pkg::XY_W-1:0] w_xs [2];
    logic signed [swd_pkg::XY_W-1:0] w_ys [2];
    logic [swd_pkg::Q_W-1:0]         w_qx [2];
    logic [swd_pkg::Q_W-1:0]         w_qy [2];
    logic [SW-1:0]                   w_speed [4];
    logic [AW-1:0]                   w_angle [4];
    logic [AW-1:0]                   r_ang [ANG_DLY][4];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= swd_pkg::LEN_RESET;
            r_track <= swd_pkg::TRACK_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swd_pkg::CFG_WHEELBASE: r_len   <= i_cfg_data;
                swd_pkg::CFG_TRACK:     r_track <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign len_eff = (r_len == '0) ? swd_pkg::LEN_W'(1) : r_len;

    swd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_fwd   (s_axis_tdata[15:0]),
        .i_rot   (s_axis_tdata[31:16]),
        .i_len   (len_eff),
        .i_track (r_track),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    swd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .o_full  (w_full),
        .i_pop   (pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    assign en  = !r_vld[LAT-1] || m_axis_tready;
    assign pop = en && w_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], w_head_valid};
        end
    end

    assign w_xs[0] = w_head.xl;
    assign w_xs[1] = w_head.xr;
    assign w_ys[0] = w_head.yf;
    assign w_ys[1] = w_head.yr;

    for (genvar j = 0; j < 2; j++) begin : g_div
        swd_div u_div_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (w_xs[j]),
            .i_len (len_eff),
            .o_q   (w_qx[j])
        );
        swd_div u_div_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (w_ys[j]),
            .i_len (len_eff),
            .o_q   (w_qy[j])
        );
    end

    for (genvar k = 0; k < 4; k++) begin : g_wheel
        swd_sqrt u_sqrt (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_qx    (w_qx[k % 2]),
            .i_qy    (w_qy[k / 2]),
            .o_speed (w_speed[k])
        );
        swd_angle u_angle (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_x     (w_xs[k % 2]),
            .i_y     (w_ys[k / 2]),
            .o_angle (w_angle[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang[0] <= w_angle;
            for (int d = 1; d < ANG_DLY; d++) begin
                r_ang[d] <= r_ang[d-1];
            end
        end
    end

    assign m_axis_tvalid = r_vld[LAT-1];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            m_axis_tdata[k*(SW+AW) +: SW]      = w_speed[k];
            m_axis_tdata[k*(SW+AW)+SW +: AW]   = r_ang[ANG_DLY-1][k];
        end
    end

endmodule

FILE: rtl/core/swd_checker.sv
module swd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:17] < 15'd23040) &&
                          (m_axis_tdata[63:49] < 15'd23040) &&
                          (m_axis_tdata[95:81] < 15'd23040) &&
                          (m_axis_tdata[127:113] < 15'd23040))
        else $error("steering angle out of range");

endmodule

bind swerve_wheel_speed_angle_unit swd_checker u_swd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/swerve_wheel_speed_angle_unit_chk.sv
module swerve_wheel_speed_angle_unit_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    input  logic         o_cfg_ready,
    input  logic [swd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swd_pkg::LEN_W-1:0]     i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ATAN_DEG [swd_pkg::CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    logic [swd_pkg::LEN_W-1:0] wheelbase_q;
    logic [swd_pkg::LEN_W-1:0] track_q;
    logic [127:0]     wheel_results_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned comp_mag(input longint v, input longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = (v < 0) ? longint'(-v) : longint'(v);
        q = (m * 256 + len) / (2 * len);
        return (q > (64'd1 << 26)) ? (64'd1 << 26) : q;
    endfunction

    function automatic longint quadrant_angle(input longint unsigned a, input longint unsigned b);
        longint unsigned m;
        longint x;
        longint y;
        longint z;
        longint nx;
        if (a == 0) return 90 * 65536;
        if (b == 0) return 0;
        m = (a > b) ? a : b;
        while (m >= (64'd1 << 30)) begin
            a = a >> 1; b = b >> 1; m = m >> 1;
        end
        while (m < (64'd1 << 29)) begin
            a = a << 1; b = b << 1; m = m << 1;
        end
        x = a;
        y = b;
        z = 0;
        for (int i = 0; i < swd_pkg::CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_DEG[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_DEG[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > 90 * 65536) z = 90 * 65536;
        return z;
    endfunction

    function automatic logic [31:0] wheel_vector(input longint x, input longint y,
                                                 input longint unsigned len);
        longint unsigned qx;
        longint unsigned qy;
        longint unsigned spd;
        longint t;
        longint total;
        longint r;
        qx = comp_mag(x, len);
        qy = comp_mag(y, len);
        spd = (int_sqrt(qx * qx + qy * qy) + 128) >> 8;
        if (spd > swd_pkg::SPEED_MAX) spd = swd_pkg::SPEED_MAX;
        if (x == 0 && y == 0) begin
            r = 0;
        end else begin
            t = quadrant_angle((x < 0) ? -x : x, (y < 0) ? -y : y);
            if (x >= 0 && y >= 0) total = t;
            else if (x < 0 && y >= 0) total = 180 * 65536 - t;
            else if (x < 0) total = 180 * 65536 + t;
            else total = 360 * 65536 - t;
            r = (total + 512) >> 10;
            if (r >= swd_pkg::ANGLE_FULL) r = r - swd_pkg::ANGLE_FULL;
        end
        return {r[swd_pkg::ANGLE_W-1:0], spd[swd_pkg::SPEED_W-1:0]};
    endfunction

    function automatic logic [127:0] wheel_set(input logic [31:0] cmd);
        longint fwd;
        longint rot;
        longint unsigned len;
        longint base;
        longint side;
        longint xl;
        longint xr;
        longint yf;
        longint yr;
        fwd = longint'($signed(cmd[15:0]));
        rot = longint'($signed(cmd[31:16]));
        len = (wheelbase_q == 0) ? 1 : wheelbase_q;
        base = fwd * 2 * longint'(len);
        side = rot * longint'(track_q);
        xl = base - side;
        xr = base + side;
        yf = rot * 3 * longint'(len);
        yr = rot * longint'(len);
        return {wheel_vector(xr, yr, len), wheel_vector(xl, yr, len),
                wheel_vector(xr, yf, len), wheel_vector(xl, yf, len)};
    endfunction

    string field_name [8] = '{"front_left_speed", "front_left_angle", "front_right_speed",
        "front_right_angle", "rear_left_speed", "rear_left_angle", "rear_right_speed",
        "rear_right_angle"};

    assign o_pending = wheel_results_q.size();

    always @(posedge i_clk) begin
        logic [127:0] exp_v;
        logic [16:0]  e_f;
        logic [16:0]  a_f;
        int           errs;
        if (!i_rst_n) begin
            wheelbase_q <= swd_pkg::LEN_RESET;
            track_q <= swd_pkg::TRACK_RESET;
            wheel_results_q.delete();
            o_fail_count <= 0;
        end else begin
            errs = 0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == swd_pkg::CFG_WHEELBASE) wheelbase_q <= i_cfg_data;
                else if (i_cfg_index == swd_pkg::CFG_TRACK) track_q <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) wheel_results_q.push_back(wheel_set(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (wheel_results_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h", $time, m_axis_tdata);
                    errs++;
                end else begin
                    exp_v = wheel_results_q.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (k % 2 == 0) begin
                            e_f = exp_v[32*(k/2) +: 17];
                            a_f = m_axis_tdata[32*(k/2) +: 17];
                        end else begin
                            e_f = {2'b0, exp_v[32*(k/2)+17 +: 15]};
                            a_f = {2'b0, m_axis_tdata[32*(k/2)+17 +: 15]};
                        end
                        if (e_f !== a_f) begin
                            $display("%0t: %s expected %0d actual %0d", $time, field_name[k],
                                     e_f, a_f);
                            errs++;
                        end
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

FILE: tb/swerve_wheel_speed_angle_unit_tb.sv
module swerve_wheel_speed_angle_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [swd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [swd_pkg::LEN_W-1:0]     i_cfg_data = '0;
    int           fail_count;
    int           pending;

    always #4 i_clk = ~i_clk;

    swerve_wheel_speed_angle_unit u_top (.*);

    swerve_wheel_speed_angle_unit_chk u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    task automatic send_cmd(input logic [15:0] fwd, input logic [15:0] rot);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rot, fwd};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_cycles(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [swd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swd_pkg::LEN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        idle_cycles(1);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h0;
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_stream(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0) begin
                send_cmd(rand_field(), rand_field());
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
        end
    endtask

    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 1300 && cyc < 1600) m_axis_tready <= 1'b0;
            else if ((cyc / 97) % 3 == 0) m_axis_tready <= 1'b1;
            else if ((cyc / 97) % 3 == 1) m_axis_tready <= ($urandom_range(0, 1) == 1);
            else m_axis_tready <= ($urandom_range(0, 7) != 0);
        end
    end

    initial begin
        #20ms;
        $display("swerve_wheel_speed_angle_unit_tb: errors");
        $finish;
    end

    logic [15:0] lens [7] = '{16'd1, 16'd65535, 16'd0, 16'd300, 16'd2500, 16'd1, 16'd700};
    logic [15:0] tracks [7] = '{16'd0, 16'd65535, 16'd500, 16'd65535, 16'd1, 16'd40000, 16'd0};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(16'h0000, 16'h0000);
        send_cmd(16'h7FFF, 16'h0000);
        send_cmd(16'h8000, 16'h0000);
        send_cmd(16'h0000, 16'h7FFF);
        send_cmd(16'h0000, 16'h8000);
        send_cmd(16'h7FFF, 16'h7FFF);
        send_cmd(16'h8000, 16'h8000);
        send_cmd(16'h7FFF, 16'h8000);
        send_cmd(16'h8000, 16'h7FFF);
        send_cmd(16'h0001, 16'h0000);
        send_cmd(16'hFFFF, 16'h0000);
        send_cmd(16'h0000, 16'h0001);
        send_cmd(16'h0000, 16'hFFFF);
        send_cmd(16'h0100, 16'h0100);
        send_cmd(16'hFF00, 16'h0100);
        random_stream(110);
        drain();

        for (int p = 0; p < 7; p++) begin
            write_reg(swd_pkg::CFG_WHEELBASE, lens[p]);
            write_reg(swd_pkg::CFG_TRACK, tracks[p]);
            if (p == 3) begin
                write_reg(2'd2, 16'h1234);
                write_reg(2'd3, 16'hFFFF);
            end
            send_cmd(16'h0000, 16'h0000);
            send_cmd(16'h0000, 16'h7FFF);
            send_cmd(16'h8000, 16'h8000);
            random_stream(200);
            drain();
        end

        write_reg(swd_pkg::CFG_WHEELBASE, 16'($urandom_range(1, 65535)));
        write_reg(swd_pkg::CFG_TRACK, 16'($urandom));
        random_stream(150);
        drain();

        if (fail_count == 0) begin
            $display("swerve_wheel_speed_angle_unit_tb: clean");
        end else begin
            $display("swerve_wheel_speed_angle_unit_tb: errors");
        end
        $finish;
    end

endmodule
